// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker of the reorder address generator.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/eoso_pkg.sv =====
// Shared types and constants of the even/odd site reorder address generator.
// No dependencies.
package eoso_pkg;

  localparam int unsigned MaxExtentDefault = 64;
  localparam int unsigned LinkDirs         = 4;
  localparam int unsigned MaxWords         = 24;
  localparam int unsigned HW               = 23;  // half site index
  localparam int unsigned WW               = 5;   // word index
  localparam int unsigned DW               = 2;   // link direction
  localparam int unsigned AW               = 31;  // word address
  localparam int unsigned XW               = 24;  // dividend 2*h
  localparam int unsigned RecipShift       = 24;
  localparam int unsigned QueueDepth       = 8;

  typedef enum logic [2:0] {
    REG_X_EXTENT   = 3'd0,
    REG_Y_EXTENT   = 3'd1,
    REG_Z_EXTENT   = 3'd2,
    REG_T_EXTENT   = 3'd3,
    REG_WORDS      = 3'd4,
    REG_LAYOUT     = 3'd5,
    REG_DIRECTION  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [HW-1:0] h;
    logic [WW-1:0] w;
    logic [DW-1:0] d;
    logic          par;
  } site_job_t;

  typedef struct packed {
    logic [AW-1:0] half_vol;
    logic [AW-1:0] two_vol;
    logic [AW-1:0] vol_words;
    logic [WW-1:0] words;
    logic          layout;
    logic          direction;
  } addr_cfg_t;

endpackage

// ===== hdl/eoso_front.sv =====
// Front part: accepts items and finds the checkerboard parity of y+z+t.
// Three reciprocal dividers in a five-register pipeline; uses eoso_pkg.
module eoso_front import eoso_pkg::*; #(
  parameter int unsigned MAX_EXTENT = MaxExtentDefault,
  localparam int unsigned EW = $clog2(MAX_EXTENT + 1),
  localparam int unsigned CW = $clog2(QueueDepth + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [HW-1:0] h_i,
  input  logic [WW-1:0] w_i,
  input  logic [DW-1:0] d_i,
  input  logic [EW-1:0] nx_i,
  input  logic [EW-1:0] ny_i,
  input  logic [EW-1:0] nz_i,
  input  logic [CW-1:0] q_count_i,
  output logic          push_o,
  output site_job_t     job_o
);

  localparam int unsigned RW  = RecipShift + 1;
  localparam int unsigned PW  = XW + RW;
  localparam int unsigned OCW = $clog2(QueueDepth + 6 + 1);

  logic [RW-1:0] recip_tab [MAX_EXTENT+1];

  for (genvar i = 0; i <= MAX_EXTENT; i++) begin : g_rcp
    localparam int unsigned Rcp = (i == 0) ? 0 : (32'd1 << RecipShift) / i;
    assign recip_tab[i] = RW'(Rcp);
  end

  // Quotient from the reciprocal estimate, one step of correction.
  // Returns the quotient above the lsb of the remainder.
  function automatic logic [XW:0] div_fix(logic [XW-1:0] x, logic [PW-1:0] p,
                                          logic [EW-1:0] n);
    logic [XW-1:0]    q;
    logic [XW+EW-1:0] r;
    q = p[RecipShift +: XW];
    r = (XW+EW)'(x) - (XW+EW)'(q) * (XW+EW)'(n);
    if (r >= (XW+EW)'(n)) begin
      q = q + XW'(1);
      r = r - (XW+EW)'(n);
    end
    return {q, r[0]};
  endfunction

  logic            v1_q, v2_q, v3_q, v4_q, v5_q;
  site_job_t       j1_q, j2_q, j3_q, j4_q, j5_q;
  logic [XW-1:0]   x1_q, x2_q, x3_q, x4_q, x5_q;
  logic [PW-1:0]   p1_q, p3_q, p5_q;
  logic            y4_q, y5_q;
  logic [XW:0]     fix2, fix4, fix6;
  logic [XW-1:0]   x_in;
  logic [OCW-1:0]  occ;
  site_job_t       j_in;

  assign occ = OCW'(q_count_i) + OCW'(v1_q) + OCW'(v2_q) + OCW'(v3_q)
             + OCW'(v4_q) + OCW'(v5_q);
  // Take an item only when a queue slot is sure to be free at its end.
  assign ready_o = (occ < OCW'(QueueDepth));

  assign x_in = {h_i, 1'b0};
  always_comb begin
    j_in     = '0;
    j_in.h   = h_i;
    j_in.w   = w_i;
    j_in.d   = d_i;
  end

  assign fix2 = div_fix(x1_q, p1_q, nx_i);
  assign fix4 = div_fix(x3_q, p3_q, ny_i);
  assign fix6 = div_fix(x5_q, p5_q, nz_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= valid_i && ready_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    j1_q <= j_in;
    x1_q <= x_in;
    p1_q <= PW'(x_in) * PW'(recip_tab[nx_i]);
    j2_q <= j1_q;
    x2_q <= fix2[XW:1];
    j3_q <= j2_q;
    x3_q <= x2_q;
    p3_q <= PW'(x2_q) * PW'(recip_tab[ny_i]);
    j4_q <= j3_q;
    x4_q <= fix4[XW:1];
    y4_q <= fix4[0];
    j5_q <= j4_q;
    x5_q <= x4_q;
    y5_q <= y4_q;
    p5_q <= PW'(x4_q) * PW'(recip_tab[nz_i]);
  end

  assign push_o = v5_q;
  always_comb begin
    job_o     = j5_q;
    job_o.par = y5_q ^ fix6[0] ^ fix6[1];
  end

endmodule

// ===== hdl/eoso_queue.sv =====
// Short queue between the front and back parts of the address generator.
// Register array with head and tail pointers; uses eoso_pkg.
module eoso_queue import eoso_pkg::*; #(
  localparam int unsigned PW = $clog2(QueueDepth),
  localparam int unsigned CW = $clog2(QueueDepth + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  site_job_t     job_i,
  input  logic          pop_i,
  output logic          valid_o,
  output site_job_t     job_o,
  output logic [CW-1:0] count_o
);

  site_job_t     mem_q [QueueDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PW'(1);
      if (pop_i)  rd_q <= rd_q + PW'(1);
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// ===== hdl/eoso_back.sv =====
// Back part: turns one classified site into the even and the odd address pair.
// Product stage, then sum stage into the output register; uses eoso_pkg.
module eoso_back import eoso_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  site_job_t     job_i,
  output logic          pop_o,
  input  addr_cfg_t     cfg_i,
  input  logic          ready_i,
  output logic          valid_o,
  output logic [AW-1:0] src_o,
  output logic [AW-1:0] dst_o,
  output logic          odd_o,
  output logic          last_o
);

  logic          half_q;
  logic          bv_q, ov_q;
  logic          adv_b, adv_c, load_b;
  logic [AW-1:0] bbase_q, bnat_q, beo_q, bw_q;
  logic          bk_q;
  logic [AW-1:0] nat_site, eo_site, base, nat_term, eo_term, w_term;
  logic [DW-1:0] dmod;
  logic [AW-1:0] nat_addr, eo_addr;

  assign adv_c  = !ov_q || ready_i;
  assign adv_b  = !bv_q || adv_c;
  assign load_b = job_valid_i && adv_b;
  assign pop_o  = load_b && half_q;

  always_comb begin
    dmod = job_i.d;
    for (int i = 0; i < 3; i++) begin
      if (32'(dmod) >= LinkDirs) dmod = dmod - DW'(LinkDirs);
    end
    nat_site = AW'({job_i.h, job_i.par ^ half_q});
    eo_site  = AW'(job_i.h) + (half_q ? cfg_i.half_vol : '0);
    base     = AW'(dmod) * cfg_i.vol_words;
    if (cfg_i.layout) begin
      nat_term = {nat_site[AW-2:0], 1'b0};
      eo_term  = {eo_site[AW-2:0], 1'b0};
      w_term   = AW'(job_i.w[WW-1:1]) * cfg_i.two_vol + AW'(job_i.w[0]);
    end else begin
      nat_term = nat_site * AW'(cfg_i.words);
      eo_term  = eo_site * AW'(cfg_i.words);
      w_term   = AW'(job_i.w);
    end
  end

  assign nat_addr = bbase_q + bnat_q + bw_q;
  assign eo_addr  = bbase_q + beo_q + bw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= 1'b0;
      bv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (load_b) half_q <= !half_q;
      if (adv_b)  bv_q   <= job_valid_i;
      if (adv_c)  ov_q   <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      bbase_q <= base;
      bnat_q  <= nat_term;
      beo_q   <= eo_term;
      bw_q    <= w_term;
      bk_q    <= half_q;
    end
    if (adv_c && bv_q) begin
      src_o  <= cfg_i.direction ? eo_addr : nat_addr;
      dst_o  <= cfg_i.direction ? nat_addr : eo_addr;
      odd_o  <= bk_q;
      last_o <= bk_q;
    end
  end

  assign valid_o = ov_q;

endmodule

// ===== hdl/even_odd_site_reorder_addresses.sv =====
// Input takes 1 item/cycle, while the 8-entry queue is sure to have room for it,
// into a 5-register divider pipeline ahead of the queue.
// The single output port carries two address pairs (even half, then odd half) per
// item, so the back part takes a new item only once it has loaded both halves of the last.
// Reset: async active low; clears handshakes, queue, and loads register defaults.
// Holds the config registers, derived volume terms, front, queue and back.
module even_odd_site_reorder_addresses import eoso_pkg::*; #(
  parameter int unsigned MAX_EXTENT = MaxExtentDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: half_site_index[22:0], word_index[27:23], link_direction[29:28]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // tdata: source_address[30:0], dest_address[61:31]; tuser: odd_half
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int unsigned EW = $clog2(MAX_EXTENT + 1);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  // Config registers, as written
  logic [6:0]    x_ext_q, y_ext_q, z_ext_q, t_ext_q;
  logic [WW-1:0] words_q;
  logic          layout_q, dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_ext_q  <= 7'd8;
      y_ext_q  <= 7'd8;
      z_ext_q  <= 7'd8;
      t_ext_q  <= 7'd8;
      words_q  <= WW'(MaxWords);
      layout_q <= 1'b0;
      dir_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_X_EXTENT:  x_ext_q  <= cfg_data_i;
        REG_Y_EXTENT:  y_ext_q  <= cfg_data_i;
        REG_Z_EXTENT:  z_ext_q  <= cfg_data_i;
        REG_T_EXTENT:  t_ext_q  <= cfg_data_i;
        REG_WORDS:     words_q  <= cfg_data_i[WW-1:0];
        REG_LAYOUT:    layout_q <= cfg_data_i[0];
        REG_DIRECTION: dir_q    <= cfg_data_i[0];
        default: ;     // drop writes beyond the register list
      endcase
    end
  end

  // Zero extent acts as 1, oversize as the maximum
  function automatic logic [EW-1:0] clamp_ext(logic [6:0] e);
    if (e == '0) return EW'(1);
    if (32'(e) > MAX_EXTENT) return EW'(MAX_EXTENT);
    return EW'(e);
  endfunction

  logic [EW-1:0] nx, ny, nz, nt;
  logic [WW-1:0] wps;

  assign nx = clamp_ext(x_ext_q);
  assign ny = clamp_ext(y_ext_q);
  assign nz = clamp_ext(z_ext_q);
  assign nt = clamp_ext(t_ext_q);

  always_comb begin
    wps = words_q;
    if (wps == '0) wps = WW'(1);
    if (32'(wps) > MaxWords) wps = WW'(MaxWords);
  end

  // Volume terms pass through nxy_q/nzt_q, vol_q and vw_q after a config write and
  // settle well before an item accepted afterwards reaches the back part.
  logic [2*EW-1:0] nxy_q, nzt_q;
  logic [4*EW-1:0] vol_q;
  logic [AW-1:0]   vw_q;
  addr_cfg_t       acfg;

  always_ff @(posedge clk_i) begin
    nxy_q <= (2*EW)'(nx) * (2*EW)'(ny);
    nzt_q <= (2*EW)'(nz) * (2*EW)'(nt);
    vol_q <= (4*EW)'(nxy_q) * (4*EW)'(nzt_q);
    vw_q  <= AW'(vol_q) * AW'(wps);
  end

  always_comb begin
    acfg.half_vol  = AW'(vol_q >> 1);
    acfg.two_vol   = AW'({vol_q, 1'b0});
    acfg.vol_words = vw_q;
    acfg.words     = wps;
    acfg.layout    = layout_q;
    acfg.direction = dir_q;
  end

  // Front: parity classification
  logic          push;
  site_job_t     push_job, head_job;
  logic          head_valid, pop;
  logic [CW-1:0] q_count;

  eoso_front #(.MAX_EXTENT(MAX_EXTENT)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .h_i       (s_axis_tdata[22:0]),
    .w_i       (s_axis_tdata[27:23]),
    .d_i       (s_axis_tdata[29:28]),
    .nx_i      (nx),
    .ny_i      (ny),
    .nz_i      (nz),
    .q_count_i (q_count),
    .push_o    (push),
    .job_o     (push_job)
  );

  eoso_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job),
    .count_o (q_count)
  );

  // Back: two address pairs per site
  logic [AW-1:0] src, dst;
  logic          odd;

  eoso_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .cfg_i       (acfg),
    .ready_i     (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .src_o       (src),
    .dst_o       (dst),
    .odd_o       (odd),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, dst, src};
  assign m_axis_tuser = odd;

endmodule

// ===== hdl/eoso_checker.sv =====
// Port-level checker for the even/odd site reorder address generator.
// Uses assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"
module eoso_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Hold a stalled result.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  // The odd half closes each item.
  `ASSERT_IMPL(a_last_is_odd, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == m_axis_tuser[0])
  // An even half is always followed by its odd half.
  `ASSERT_NEXT(a_even_then_odd, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tuser[0], !m_axis_tvalid || m_axis_tuser[0])

endmodule

bind even_odd_site_reorder_addresses eoso_checker u_eoso_checker (.*);
